// File: rtl/core/itw_pkg.sv
// shared constants and types for the interpolated table waveshaper
// no dependencies
package itw_pkg;

  localparam int DATA_W          = 16;
  localparam int IDX_W           = 10;
  localparam int CFG_W           = 11;
  localparam int FRAC_W          = 14;
  localparam int HALF_W          = CFG_W - 1;
  localparam int POS_W           = HALF_W + DATA_W;
  localparam int JR_W            = POS_W - FRAC_W;
  localparam int PROD_W          = 32;
  localparam int DEF_TABLE_DEPTH = 1024;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SHAPE = 1'b1
  } op_t;

  typedef struct packed {
    logic valid;
    logic shape;
    logic bypass;
    logic load_ok;
  } stage_ctrl_t;

endpackage

// File: rtl/core/itw_ifs.sv
// beat channels of the interpolated table waveshaper
// depends on itw_pkg
interface itw_item_if;
  import itw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         table_index;
  logic signed [DATA_W-1:0] table_value;
  logic signed [DATA_W-1:0] sample_in;

  modport source (output valid, opcode, table_index, table_value, sample_in, input ready);
  modport sink   (input valid, opcode, table_index, table_value, sample_in, output ready);
endinterface

interface itw_result_if;
  import itw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface itw_cfg_if;
  import itw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_points;

  modport source (output valid, num_points, input ready);
  modport sink   (input valid, num_points, output ready);
endinterface

// File: rtl/core/itw_map.sv
// clamp, position multiply and neighbor index stages (three register stages)
// depends on itw_pkg
module itw_map #(
  parameter int TABLE_DEPTH = itw_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic [itw_pkg::CFG_W-1:0]                num_points,
  input  logic                                     in_valid,
  input  logic                                     opcode,
  input  logic [itw_pkg::IDX_W-1:0]                table_index,
  input  logic signed [itw_pkg::DATA_W-1:0]        table_value,
  input  logic signed [itw_pkg::DATA_W-1:0]        sample_in,
  output itw_pkg::stage_ctrl_t                     c3,
  output logic [$clog2(TABLE_DEPTH)-1:0]           j3,
  output logic [$clog2(TABLE_DEPTH)-1:0]           k3,
  output logic [$clog2(TABLE_DEPTH)-1:0]           waddr3,
  output logic [itw_pkg::FRAC_W-1:0]               d3,
  output logic signed [itw_pkg::DATA_W-1:0]        data3
);
  import itw_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic signed [DATA_W:0] POS_ONE = (DATA_W+1)'(1 << FRAC_W);
  localparam logic signed [DATA_W:0] NEG_ONE = -POS_ONE;

  logic [CFG_W-1:0]         n;
  logic [CFG_W-1:0]         last;
  logic [HALF_W-1:0]        half;
  logic signed [DATA_W:0]   xw;
  logic signed [DATA_W:0]   xc;
  logic [JR_W-1:0]          jr;
  logic [JR_W-1:0]          jc;
  logic [JR_W-1:0]          kc;

  stage_ctrl_t              c1, c2;
  logic [DATA_W-1:0]        xo1;
  logic signed [DATA_W-1:0] data1, data2;
  logic [AW-1:0]            addr1, addr2;
  logic [POS_W-1:0]         p2;

  always_comb begin
    if (int'(num_points) > TABLE_DEPTH) begin
      n = CFG_W'(TABLE_DEPTH);
    end else begin
      n = num_points;
    end
    last = n - 1'b1;
    half = n[CFG_W-1:1];
    xw   = {sample_in[DATA_W-1], sample_in};
    if (xw < NEG_ONE) begin
      xc = NEG_ONE;
    end else if (xw > POS_ONE) begin
      xc = POS_ONE;
    end else begin
      xc = xw;
    end
    jr = p2[POS_W-1:FRAC_W];
    jc = (jr > JR_W'(last)) ? JR_W'(last) : jr;
    kc = (jc < JR_W'(last)) ? jc + 1'b1 : JR_W'(last);
  end

  // stage 1: clamp and offset
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (en) begin
      c1.valid   <= in_valid;
      c1.shape   <= (op_t'(opcode) == OP_SHAPE);
      c1.bypass  <= (n == '0);
      c1.load_ok <= (int'(table_index) < TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xo1   <= DATA_W'(xc + POS_ONE);
      data1 <= (op_t'(opcode) == OP_SHAPE) ? sample_in : table_value;
      addr1 <= AW'(table_index);
    end
  end

  // stage 2: position
  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else if (en) begin
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2    <= POS_W'(half) * POS_W'(xo1);
      data2 <= data1;
      addr2 <= addr1;
    end
  end

  // stage 3: neighbor indices and fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      c3 <= '0;
    end else if (en) begin
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j3     <= AW'(jc);
      k3     <= AW'(kc);
      d3     <= p2[FRAC_W-1:0];
      data3  <= data2;
      waddr3 <= addr2;
    end
  end

`ifndef SYNTHESIS
  a_k_not_below_j: assert property (@(posedge clk) disable iff (rst)
    c3.valid && c3.shape && !c3.bypass |-> j3 <= k3)
    else $error("upper neighbor below lower neighbor");
  a_k_adjacent: assert property (@(posedge clk) disable iff (rst)
    c3.valid && c3.shape && !c3.bypass |-> (k3 == j3) || (k3 == j3 + 1'b1))
    else $error("neighbors not adjacent");
  a_k_in_table: assert property (@(posedge clk) disable iff (rst)
    c3.valid && c3.shape && !c3.bypass |-> int'(k3) < TABLE_DEPTH)
    else $error("neighbor index past table end");
`endif

endmodule

// File: rtl/core/itw_table.sv
// transfer table memory, one write port and two registered read ports
// depends on itw_pkg
module itw_table #(
  parameter int TABLE_DEPTH = itw_pkg::DEF_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  itw_pkg::stage_ctrl_t               c3,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     j3,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     k3,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     waddr3,
  input  logic [itw_pkg::FRAC_W-1:0]         d3,
  input  logic signed [itw_pkg::DATA_W-1:0]  data3,
  output itw_pkg::stage_ctrl_t               c4,
  output logic signed [itw_pkg::DATA_W-1:0]  t0_4,
  output logic signed [itw_pkg::DATA_W-1:0]  t1_4,
  output logic [itw_pkg::FRAC_W-1:0]         d4,
  output logic signed [itw_pkg::DATA_W-1:0]  data4
);
  import itw_pkg::*;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (en && c3.valid && !c3.shape && c3.load_ok) begin
      mem[waddr3] <= data3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_4  <= mem[j3];
      t1_4  <= mem[k3];
      d4    <= d3;
      data4 <= data3;
    end
  end

  // load beats end here
  always_ff @(posedge clk) begin
    if (rst) begin
      c4 <= '0;
    end else if (en) begin
      c4 <= '{valid:   c3.valid && c3.shape,
              shape:   c3.shape,
              bypass:  c3.bypass,
              load_ok: c3.load_ok};
    end
  end

endmodule

// File: rtl/core/itw_interp.sv
// interpolation multiply stage and output add register
// depends on itw_pkg
module itw_interp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  itw_pkg::stage_ctrl_t               c4,
  input  logic signed [itw_pkg::DATA_W-1:0]  t0_4,
  input  logic signed [itw_pkg::DATA_W-1:0]  t1_4,
  input  logic [itw_pkg::FRAC_W-1:0]         d4,
  input  logic signed [itw_pkg::DATA_W-1:0]  data4,
  output logic                               out_valid,
  output logic signed [itw_pkg::DATA_W-1:0]  out_sample
);
  import itw_pkg::*;

  stage_ctrl_t              c5;
  logic signed [DATA_W:0]   diff;
  logic signed [PROD_W-1:0] prod5;
  logic signed [DATA_W-1:0] t0_5;
  logic signed [DATA_W-1:0] data5;
  logic signed [DATA_W-1:0] y;

  assign diff = {t1_4[DATA_W-1], t1_4} - {t0_4[DATA_W-1], t0_4};
  // floored product, result always between the two entries
  assign y    = t0_5 + DATA_W'(prod5 >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      c5 <= '0;
    end else if (en) begin
      c5 <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod5 <= PROD_W'($signed({1'b0, d4}) * diff);
      t0_5  <= t0_4;
      data5 <= data4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sample <= c5.bypass ? data5 : y;
    end
  end

endmodule

// File: rtl/core/interpolated_table_waveshaper_unit.sv
// top level of the interpolated table waveshaper
// depends on itw_pkg, itw_ifs, itw_map, itw_table, itw_interp
//
// channel   dir  fields
// items     in   opcode, table_index, table_value, sample_in
// results   out  sample_out (one beat per shape item, none per load)
// cfg       in   num_points (always ready)
//
// one item per cycle unless the output stalls; results leave from the output register
// the pipeline advances as a whole whenever the output register is empty or taken
// a stalled output freezes every stage, so nothing is lost or repeated
// reset clears num_points and the stage valid bits; the table is unknown until loaded
module interpolated_table_waveshaper_unit #(
  parameter int TABLE_DEPTH = itw_pkg::DEF_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  itw_item_if.sink     items,
  itw_result_if.source results,
  itw_cfg_if.sink      cfg
);
  import itw_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                     en;
  logic [CFG_W-1:0]         num_points;
  stage_ctrl_t              c3, c4;
  logic [AW-1:0]            j3, k3, waddr3;
  logic [FRAC_W-1:0]        d3, d4;
  logic signed [DATA_W-1:0] data3, data4, t0_4, t1_4;

  assign en          = !results.valid || results.ready;
  assign items.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= '0;
    end else if (cfg.valid) begin
      num_points <= cfg.num_points;
    end
  end

  itw_map #(.TABLE_DEPTH(TABLE_DEPTH)) u_map (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .num_points  (num_points),
    .in_valid    (items.valid),
    .opcode      (items.opcode),
    .table_index (items.table_index),
    .table_value (items.table_value),
    .sample_in   (items.sample_in),
    .c3          (c3),
    .j3          (j3),
    .k3          (k3),
    .waddr3      (waddr3),
    .d3          (d3),
    .data3       (data3)
  );

  itw_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .c3     (c3),
    .j3     (j3),
    .k3     (k3),
    .waddr3 (waddr3),
    .d3     (d3),
    .data3  (data3),
    .c4     (c4),
    .t0_4   (t0_4),
    .t1_4   (t1_4),
    .d4     (d4),
    .data4  (data4)
  );

  itw_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .c4         (c4),
    .t0_4       (t0_4),
    .t1_4       (t1_4),
    .d4         (d4),
    .data4      (data4),
    .out_valid  (results.valid),
    .out_sample (results.sample_out)
  );

`ifndef SYNTHESIS
  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !items.ready)
    else $error("item taken while output stalled");
`endif

endmodule
